// File: src/csl_pkg.sv
// Package for the cache set LRU replacement core: types, codes and widths.
`default_nettype none
package csl_pkg;

    localparam int MAX_WAYS_DEF = 8;

    localparam int TAG_W       = 32;
    localparam int ACTION_W    = 2;
    localparam int XFER_W      = 2;
    localparam int WIU_W       = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // stream field positions
    localparam int IN_ACTION_LSB = 0;
    localparam int IN_TAG_LSB    = ACTION_W;
    localparam int OUT_HIT_LSB   = 0;
    localparam int OUT_XFER_LSB  = 1;
    localparam int OUT_PAD_W     = OUT_TDATA_W - 1 - XFER_W;

    localparam logic [WIU_W-1:0] WAYS_IN_USE_RST = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_THROUGH = 8'd1;

    localparam logic [XFER_W-1:0] XFER_NONE  = 2'd0;
    localparam logic [XFER_W-1:0] XFER_FILL  = 2'd1;
    localparam logic [XFER_W-1:0] XFER_WBACK = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_TOUCH  = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_DIRTY  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_UPDATE = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;  // latch the incoming item
        logic search;   // register tag match, victim and free way
        logic commit;   // update the set and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic out_full; // result register holds an untaken result
    } t_dp_status;

endpackage
`default_nettype wire

// File: src/cache_set_lru_replacement_core.sv
// Top level of the cache set LRU replacement core: stream ports, controller and datapath.
//
// One set of a set-associative cache with least-recently-used replacement. Each input
// transfer carries an action (lookup, touch, add, mark dirty) and a 32-bit tag; each
// produces exactly one result transfer with the hit flag and, for an add that misses,
// the number of block transfers (1, or 2 when a dirty victim is written back). Every
// item passes an accept step, a search step for the parallel tag compare and victim
// and free-way selection across all ways, and an update step for tags, dirty marks,
// ages and the result register; the next item is accepted in the cycle after that
// update. The result register lets a new item start while a result waits; the update
// step stalls only if the previous result is still untaken. The configuration port is
// ready whenever reset is released; write it only while the core is idle. Register 0
// sets the ways in use (0 acts as 1, above MAX_WAYS acts as MAX_WAYS), register 1
// selects write-through.
`default_nettype none
module cache_set_lru_replacement_core #(
    parameter int MAX_WAYS = csl_pkg::MAX_WAYS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // tdata: [1:0] action, [33:2] tag, [39:34] zero
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [csl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tdata: [0] hit, [2:1] transfer_count, [7:3] zero
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [csl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [csl_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire [csl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    csl_pkg::t_dp_cmd            w_cmd;
    csl_pkg::t_dp_status         w_status;
    logic [csl_pkg::ACTION_W-1:0] w_action;
    logic [csl_pkg::TAG_W-1:0]   w_tag;
    logic                        w_out_hit;
    logic [csl_pkg::XFER_W-1:0]  w_out_xfer;

    assign w_action = s_axis_tdata[csl_pkg::IN_ACTION_LSB +: csl_pkg::ACTION_W];
    assign w_tag    = s_axis_tdata[csl_pkg::IN_TAG_LSB +: csl_pkg::TAG_W];

    assign o_cfg_ready  = i_rst_n;
    assign m_axis_tdata = {{csl_pkg::OUT_PAD_W{1'b0}}, w_out_xfer, w_out_hit};

    csl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    csl_dpath #(
        .MAX_WAYS (MAX_WAYS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_action    (w_action),
        .i_tag       (w_tag),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_hit   (w_out_hit),
        .o_out_xfer  (w_out_xfer)
    );

endmodule
`default_nettype wire

// File: src/csl_ctrl.sv
// Controller state machine of the cache set core: sequences capture, search and commit.
`default_nettype none
module csl_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_out_ready,
    input  csl_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output csl_pkg::t_dp_cmd      o_cmd
);

    csl_pkg::t_state r_state;
    csl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            csl_pkg::ST_IDLE: begin
                // no transfer is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = csl_pkg::ST_SEARCH;
                end
            end
            csl_pkg::ST_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = csl_pkg::ST_UPDATE;
            end
            csl_pkg::ST_UPDATE: begin
                // hold until the result register is free or being emptied
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = csl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/csl_dpath.sv
// Datapath of the cache set core: way state, tag match, LRU ages, config and result register.
`default_nettype none
module csl_dpath #(
    parameter int MAX_WAYS = csl_pkg::MAX_WAYS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  csl_pkg::t_dp_cmd                   i_cmd,
    output csl_pkg::t_dp_status                o_status,
    input  wire [csl_pkg::ACTION_W-1:0]        i_action,
    input  wire [csl_pkg::TAG_W-1:0]           i_tag,
    input  wire                                i_cfg_valid,
    input  wire [csl_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire [csl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_out_hit,
    output logic [csl_pkg::XFER_W-1:0]         o_out_xfer
);

    localparam int AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int OW = $clog2(MAX_WAYS + 1);
    localparam int LW = (OW > csl_pkg::WIU_W) ? OW : csl_pkg::WIU_W;

    // configuration
    logic [csl_pkg::WIU_W-1:0] r_ways_in_use;
    logic                      r_write_through;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use   <= csl_pkg::WAYS_IN_USE_RST;
            r_write_through <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == csl_pkg::CFG_WAYS_IN_USE) begin
                r_ways_in_use <= i_cfg_data;
            end else if (i_cfg_index == csl_pkg::CFG_WRITE_THROUGH) begin
                r_write_through <= i_cfg_data[0];
            end
        end
    end

    // way state
    logic [csl_pkg::TAG_W-1:0] r_way_tag [MAX_WAYS];
    logic [MAX_WAYS-1:0]       r_way_valid;
    logic [MAX_WAYS-1:0]       r_way_dirty;
    logic [AW-1:0]             r_way_age [MAX_WAYS];
    logic [OW-1:0]             r_occ;

    logic [MAX_WAYS-1:0]       n_way_valid;
    logic [MAX_WAYS-1:0]       n_way_dirty;
    logic [AW-1:0]             n_way_age [MAX_WAYS];
    logic [OW-1:0]             n_occ;
    logic [MAX_WAYS-1:0]       w_slot_wr;

    // captured item and search results
    csl_pkg::t_action          r_action;
    logic [csl_pkg::TAG_W-1:0] r_tag;
    logic [MAX_WAYS-1:0]       r_hit_vec;
    logic [MAX_WAYS-1:0]       r_victim;
    logic [MAX_WAYS-1:0]       r_free;
    logic                      r_full;

    // result register
    logic                      r_out_valid;
    logic                      r_out_hit;
    logic [csl_pkg::XFER_W-1:0] r_out_xfer;
    logic                      n_out_hit;
    logic [csl_pkg::XFER_W-1:0] n_out_xfer;

    // search stage logic
    logic [MAX_WAYS-1:0] w_hit_vec;
    logic [MAX_WAYS-1:0] w_victim;
    logic [MAX_WAYS-1:0] w_invalid;
    logic [MAX_WAYS-1:0] w_free;
    logic [OW-1:0]       w_oldest_age;
    logic [LW-1:0]       w_wiu;
    logic [LW-1:0]       w_limit;
    logic                w_full;

    always_comb begin
        w_oldest_age = r_occ - OW'(1);
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_hit_vec[i] = r_way_valid[i] && (r_way_tag[i] == r_tag);
            w_victim[i]  = r_way_valid[i] && (OW'(r_way_age[i]) == w_oldest_age);
        end
        w_invalid = ~r_way_valid;
        // lowest free way
        w_free    = w_invalid & (~w_invalid + MAX_WAYS'(1));
        w_wiu     = LW'(r_ways_in_use);
        if (w_wiu == '0) begin
            w_limit = LW'(1);
        end else if (w_wiu > LW'(MAX_WAYS)) begin
            w_limit = LW'(MAX_WAYS);
        end else begin
            w_limit = w_wiu;
        end
        w_full = LW'(r_occ) >= w_limit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= csl_pkg::t_action'(i_action);
            r_tag    <= i_tag;
        end
        if (i_cmd.search) begin
            r_hit_vec <= w_hit_vec;
            r_victim  <= w_victim;
            r_free    <= w_free;
            r_full    <= w_full;
        end
    end

    // commit stage logic
    logic [AW-1:0]       w_hit_age;
    logic                w_hit;
    logic [MAX_WAYS-1:0] w_slot;

    always_comb begin
        w_hit     = |r_hit_vec;
        w_hit_age = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_hit_age = w_hit_age | (r_way_age[i] & {AW{r_hit_vec[i]}});
        end
        w_slot = r_full ? r_victim : r_free;

        n_way_valid = r_way_valid;
        n_way_dirty = r_way_dirty;
        n_occ       = r_occ;
        w_slot_wr   = '0;
        n_out_hit   = w_hit;
        n_out_xfer  = csl_pkg::XFER_NONE;
        for (int i = 0; i < MAX_WAYS; i++) begin
            n_way_age[i] = r_way_age[i];
        end

        case (r_action)
            csl_pkg::ACT_TOUCH, csl_pkg::ACT_ADD: begin
                if (w_hit) begin
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (r_hit_vec[i]) begin
                            n_way_age[i] = '0;
                        end else if (r_way_valid[i] && (r_way_age[i] < w_hit_age)) begin
                            n_way_age[i] = r_way_age[i] + AW'(1);
                        end
                    end
                end else if (r_action == csl_pkg::ACT_ADD) begin
                    if (r_full && |(r_victim & r_way_dirty) && !r_write_through) begin
                        n_out_xfer = csl_pkg::XFER_WBACK;
                    end else begin
                        n_out_xfer = csl_pkg::XFER_FILL;
                    end
                    w_slot_wr = w_slot;
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (w_slot[i]) begin
                            n_way_valid[i] = 1'b1;
                            n_way_dirty[i] = 1'b0;
                            n_way_age[i]   = '0;
                        end else if (r_way_valid[i]) begin
                            n_way_age[i] = r_way_age[i] + AW'(1);
                        end
                    end
                    // an eviction reuses the victim's way, so occupancy holds
                    if (!r_full) begin
                        n_occ = r_occ + OW'(1);
                    end
                end
            end
            csl_pkg::ACT_DIRTY: begin
                n_way_dirty = r_way_dirty | r_hit_vec;
            end
            default: begin
                n_way_valid = r_way_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way_valid <= '0;
            r_way_dirty <= '0;
            r_occ       <= '0;
            for (int i = 0; i < MAX_WAYS; i++) begin
                r_way_age[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_way_valid <= n_way_valid;
            r_way_dirty <= n_way_dirty;
            r_occ       <= n_occ;
            for (int i = 0; i < MAX_WAYS; i++) begin
                r_way_age[i] <= n_way_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_cmd.commit && w_slot_wr[i]) begin
                r_way_tag[i] <= r_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit  <= n_out_hit;
            r_out_xfer <= n_out_xfer;
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out_hit         = r_out_hit;
    assign o_out_xfer        = r_out_xfer;

endmodule
`default_nettype wire
